FILE: rtl/dvr_pkg.sv
// ----------------------------------------------------------------------------
// dvr_pkg
// Shared types, constants and helpers for the distance-vector route update
// block: table geometry, the stored route entry and controller commands.
// ----------------------------------------------------------------------------
package dvr_pkg;

   // Table geometry
   localparam int TABLE_DEPTH = 32;
   localparam int ADDR_WIDTH  = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   // Fixed field widths at the ports
   localparam int FIELD_ADDR_W  = 32;
   localparam int FIELD_INDEX_W = 5;
   localparam int COST_W        = 8;

   localparam logic [COST_W-1:0] MAX_METRIC_RESET = 8'd16;

   // One stored route
   typedef struct packed {
      logic [ADDR_WIDTH-1:0] dest;
      logic [COST_W-1:0]     cost;
      logic [ADDR_WIDTH-1:0] next_hop;
      logic [ADDR_WIDTH-1:0] iface;
   } route_entry_type;

   localparam int ENTRY_W = $bits(route_entry_type);

   // Controller to datapath
   typedef struct packed {
      logic load;     // capture a new request, restart the scan
      logic scan;     // compare the entry read this cycle
      logic commit;   // write the table and the response register
   } dvr_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic hit;        // entry under scan matches the destination
      logic scan_last;  // entry under scan is the last valid one
      logic empty;      // table holds no routes
   } dvr_status_type;

   // Port address field to stored address width
   function automatic logic [ADDR_WIDTH-1:0] to_addr(input logic [FIELD_ADDR_W-1:0] val);
      logic [ADDR_WIDTH+FIELD_ADDR_W-1:0] wide;
      wide = {{ADDR_WIDTH{1'b0}}, val};
      return wide[ADDR_WIDTH-1:0];
   endfunction

   // Stored address to port field width
   function automatic logic [FIELD_ADDR_W-1:0] to_field(input logic [ADDR_WIDTH-1:0] val);
      logic [ADDR_WIDTH+FIELD_ADDR_W-1:0] wide;
      wide = {{FIELD_ADDR_W{1'b0}}, val};
      return wide[FIELD_ADDR_W-1:0];
   endfunction

   // Table slot to the index field
   function automatic logic [FIELD_INDEX_W-1:0] idx_to_field(input logic [IDX_W-1:0] val);
      logic [IDX_W+FIELD_INDEX_W-1:0] wide;
      wide = {{FIELD_INDEX_W{1'b0}}, val};
      return wide[FIELD_INDEX_W-1:0];
   endfunction

endpackage

FILE: rtl/dvr_ram.sv
// ----------------------------------------------------------------------------
// dvr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/dvr_datapath.sv
// ----------------------------------------------------------------------------
// dvr_datapath
// Request registers, route table, scan pointer, update decision and the
// response register.
// ----------------------------------------------------------------------------
module dvr_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  dvr_pkg::dvr_cmd_type                cmd,
   output dvr_pkg::dvr_status_type             status,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [dvr_pkg::COST_W-1:0]          csr_wr_data,
   // request payload
   input  logic                                req_mode,
   input  logic [dvr_pkg::FIELD_ADDR_W-1:0]    req_dest_addr,
   input  logic [dvr_pkg::COST_W-1:0]          req_adv_cost,
   input  logic [dvr_pkg::FIELD_ADDR_W-1:0]    req_neighbor_addr,
   input  logic [dvr_pkg::FIELD_ADDR_W-1:0]    req_local_if_addr,
   input  logic                                req_last_of_message,
   // response payload
   output logic [dvr_pkg::FIELD_INDEX_W-1:0]   rsp_entry_index,
   output logic [dvr_pkg::COST_W-1:0]          rsp_entry_cost,
   output logic [dvr_pkg::FIELD_ADDR_W-1:0]    rsp_entry_next_hop,
   output logic [dvr_pkg::FIELD_ADDR_W-1:0]    rsp_entry_iface,
   output logic                                rsp_entry_changed,
   output logic                                rsp_table_full,
   output logic                                rsp_message_changed,
   output logic                                rsp_result_last
);
   import dvr_pkg::*;

   // Configuration and persistent state
   logic [COST_W-1:0]     max_metric_ff;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic                  chg_msg_ff, chg_msg_in;

   // Captured request
   logic                  mode_ff;
   logic [ADDR_WIDTH-1:0] dest_ff, nbr_ff, lif_ff;
   logic [COST_W-1:0]     cand_ff, cand_in;
   logic                  last_ff;

   // Scan
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic                  found_ff;
   route_entry_type       ent_ff;
   route_entry_type       rd_entry;
   logic [ENTRY_W-1:0]    rd_data;

   // Update
   logic [COST_W:0]       cand_wide;
   route_entry_type       upd_entry;
   logic [IDX_W-1:0]      slot;
   logic                  changed, full, wr_en;

   // Response register
   logic [FIELD_INDEX_W-1:0] out_index_ff;
   logic [COST_W-1:0]        out_cost_ff;
   logic [FIELD_ADDR_W-1:0]  out_nh_ff, out_if_ff;
   logic                     out_changed_ff, out_full_ff, out_msg_ff, out_last_ff;

   // Route table
   dvr_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (slot),
      .wr_data (upd_entry),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   assign rd_entry = route_entry_type'(rd_data);

   // Candidate cost: neighbour routes cost one more, saturating at infinity
   always_comb begin
      cand_wide = {1'b0, req_adv_cost} + {{COST_W{1'b0}}, 1'b1};
      if (req_mode) begin
         cand_in = req_adv_cost;
      end else if (cand_wide > {1'b0, max_metric_ff}) begin
         cand_in = max_metric_ff;
      end else begin
         cand_in = cand_wide[COST_W-1:0];
      end
   end

   // Scan status and pointer; read address runs one step ahead of idx_ff
   always_comb begin
      status.hit       = (rd_entry.dest == dest_ff);
      status.scan_last = (({1'b0, idx_ff} + {{IDX_W{1'b0}}, 1'b1}) == count_ff);
      status.empty     = (count_ff == '0);
      if (cmd.load) begin
         idx_in = '0;
      end else if (cmd.scan && !status.hit && !status.scan_last) begin
         idx_in = idx_ff + {{(IDX_W-1){1'b0}}, 1'b1};
      end else begin
         idx_in = idx_ff;
      end
   end

   // Update decision
   always_comb begin
      upd_entry = ent_ff;
      changed   = 1'b0;
      full      = 1'b0;
      slot      = idx_ff;
      count_in  = count_ff;
      if (found_ff) begin
         if (mode_ff) begin
            upd_entry.cost     = cand_ff;
            upd_entry.next_hop = nbr_ff;
            upd_entry.iface    = lif_ff;
            changed = (ent_ff.cost != cand_ff) || (ent_ff.next_hop != nbr_ff) ||
                      (ent_ff.iface != lif_ff);
         end else if (cand_ff < ent_ff.cost) begin
            upd_entry.cost     = cand_ff;
            upd_entry.next_hop = nbr_ff;
            upd_entry.iface    = lif_ff;
            changed = 1'b1;
         end else if ((ent_ff.next_hop == nbr_ff) && (ent_ff.cost != cand_ff)) begin
            upd_entry.cost = cand_ff;
            changed = 1'b1;
         end
      end else if (count_ff < CNT_W'(TABLE_DEPTH)) begin
         // new destination goes in the next free slot
         slot               = count_ff[IDX_W-1:0];
         upd_entry.dest     = dest_ff;
         upd_entry.cost     = cand_ff;
         upd_entry.next_hop = nbr_ff;
         upd_entry.iface    = lif_ff;
         changed  = 1'b1;
         count_in = count_ff + {{IDX_W{1'b0}}, 1'b1};
      end else begin
         full = 1'b1;
      end
      chg_msg_in = last_ff ? 1'b0 : (chg_msg_ff | changed);
      wr_en      = cmd.commit && !full;
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         max_metric_ff <= MAX_METRIC_RESET;
         count_ff      <= '0;
         chg_msg_ff    <= 1'b0;
         idx_ff        <= '0;
         found_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_metric_ff <= csr_wr_data;
         end
         idx_ff <= idx_in;
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.scan) begin
            found_ff <= status.hit;
         end
         if (cmd.commit) begin
            count_ff   <= count_in;
            chg_msg_ff <= chg_msg_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_mode;
         dest_ff <= to_addr(req_dest_addr);
         nbr_ff  <= to_addr(req_neighbor_addr);
         lif_ff  <= to_addr(req_local_if_addr);
         cand_ff <= cand_in;
         last_ff <= req_last_of_message;
      end
      if (cmd.scan) begin
         ent_ff <= rd_entry;
      end
      if (cmd.commit) begin
         out_index_ff   <= full ? '0 : idx_to_field(slot);
         out_cost_ff    <= full ? '0 : upd_entry.cost;
         out_nh_ff      <= full ? '0 : to_field(upd_entry.next_hop);
         out_if_ff      <= full ? '0 : to_field(upd_entry.iface);
         out_changed_ff <= changed;
         out_full_ff    <= full;
         out_msg_ff     <= last_ff && (chg_msg_ff || changed);
         out_last_ff    <= last_ff;
      end
   end

   assign rsp_entry_index     = out_index_ff;
   assign rsp_entry_cost      = out_cost_ff;
   assign rsp_entry_next_hop  = out_nh_ff;
   assign rsp_entry_iface     = out_if_ff;
   assign rsp_entry_changed   = out_changed_ff;
   assign rsp_table_full      = out_full_ff;
   assign rsp_message_changed = out_msg_ff;
   assign rsp_result_last     = out_last_ff;

endmodule

FILE: rtl/dvr_ctrl.sv
// ----------------------------------------------------------------------------
// dvr_ctrl
// Controller: accepts a request, steps the table scan, commits the update
// when the response register is free, and owns the response valid flag.
// ----------------------------------------------------------------------------
module dvr_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dvr_pkg::dvr_cmd_type    cmd,
   input  dvr_pkg::dvr_status_type status
);
   import dvr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_ready  = (state_ff == ST_IDLE);
      out_free   = !rsp_valid_ff || rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = status.empty ? ST_UPDATE : ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.scan = 1'b1;
            if (status.hit || status.scan_last) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/distance_vector_route_update_top.sv
// ----------------------------------------------------------------------------
// distance_vector_route_update_top
// Distance-vector route table update: one advertised or direct route per
// request, one response per request reporting the table slot touched.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* is a valid/ready channel carrying one route per request.
//    req_ready is high only while the block is idle.
//  - rsp_* is a valid/ready channel with one response per request, held in
//    an output register; the next request is taken while it waits.
//  - csr_wr_en/csr_wr_data write max_metric; write only while idle.
//  - Steps: accept, scan the table entries in order until a match or the last
//    valid entry (no scan for an empty table), then commit. The scan rate is
//    set by the one read port of the table RAM.
//  - If the receiver stalls, a finished item waits in the update state until
//    the response register frees; no request is accepted meanwhile.
//  - Reset empties the table (entry count zero), clears the message change
//    flag and sets max_metric to 16. No clearing pass is needed.
// ----------------------------------------------------------------------------
module distance_vector_route_update_top (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [dvr_pkg::COST_W-1:0]          csr_wr_data,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [dvr_pkg::FIELD_ADDR_W-1:0]    req_dest_addr,
   input  logic [dvr_pkg::COST_W-1:0]          req_adv_cost,
   input  logic [dvr_pkg::FIELD_ADDR_W-1:0]    req_neighbor_addr,
   input  logic [dvr_pkg::FIELD_ADDR_W-1:0]    req_local_if_addr,
   input  logic                                req_last_of_message,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dvr_pkg::FIELD_INDEX_W-1:0]   rsp_entry_index,
   output logic [dvr_pkg::COST_W-1:0]          rsp_entry_cost,
   output logic [dvr_pkg::FIELD_ADDR_W-1:0]    rsp_entry_next_hop,
   output logic [dvr_pkg::FIELD_ADDR_W-1:0]    rsp_entry_iface,
   output logic                                rsp_entry_changed,
   output logic                                rsp_table_full,
   output logic                                rsp_message_changed,
   output logic                                rsp_result_last
);
   import dvr_pkg::*;

   dvr_cmd_type    cmd;
   dvr_status_type status;

   // Controller
   dvr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath and route table
   dvr_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_mode            (req_mode),
      .req_dest_addr       (req_dest_addr),
      .req_adv_cost        (req_adv_cost),
      .req_neighbor_addr   (req_neighbor_addr),
      .req_local_if_addr   (req_local_if_addr),
      .req_last_of_message (req_last_of_message),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_cost      (rsp_entry_cost),
      .rsp_entry_next_hop  (rsp_entry_next_hop),
      .rsp_entry_iface     (rsp_entry_iface),
      .rsp_entry_changed   (rsp_entry_changed),
      .rsp_table_full      (rsp_table_full),
      .rsp_message_changed (rsp_message_changed),
      .rsp_result_last     (rsp_result_last)
   );

endmodule

FILE: test/tb_distance_vector_route_update_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distance_vector_route_update_top
// Self-checking bench for the distance-vector route update block. Requests
// are fed from a queue by a clocked driver. A shadow route table predicts
// every response at the moment its request is accepted. A clocked monitor
// checks each response field by field. The run covers several max_metric
// settings and three patterns of back-pressure.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_update_top;

   import dvr_pkg::*;

   localparam logic ROUTE_ADVERTISED = 1'b0;
   localparam logic ROUTE_DIRECT     = 1'b1;

   localparam int DEST_POOL_N  = 44;   // more than the table holds, so drops occur
   localparam int NBR_POOL_N   = 4;
   localparam int IFACE_POOL_N = 3;
   localparam int SETTLE_CYC   = 40;   // longest scan plus commit, with margin
   localparam int STALL_LIMIT  = 2000;

   typedef struct packed {
      logic                    mode;
      logic [FIELD_ADDR_W-1:0] dest;
      logic [COST_W-1:0]       cost;
      logic [FIELD_ADDR_W-1:0] neighbor;
      logic [FIELD_ADDR_W-1:0] iface;
      logic                    last;
   } route_req_type;

   typedef struct packed {
      logic [FIELD_INDEX_W-1:0] index;
      logic [COST_W-1:0]        cost;
      logic [FIELD_ADDR_W-1:0]  next_hop;
      logic [FIELD_ADDR_W-1:0]  iface;
      logic                     changed;
      logic                     full;
      logic                     msg_changed;
      logic                     last;
   } route_rsp_type;

   // DUT ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [COST_W-1:0]        csr_wr_data = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_mode = 1'b0;
   logic [FIELD_ADDR_W-1:0]  req_dest_addr = '0;
   logic [COST_W-1:0]        req_adv_cost = '0;
   logic [FIELD_ADDR_W-1:0]  req_neighbor_addr = '0;
   logic [FIELD_ADDR_W-1:0]  req_local_if_addr = '0;
   logic                     req_last_of_message = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [FIELD_INDEX_W-1:0] rsp_entry_index;
   logic [COST_W-1:0]        rsp_entry_cost;
   logic [FIELD_ADDR_W-1:0]  rsp_entry_next_hop;
   logic [FIELD_ADDR_W-1:0]  rsp_entry_iface;
   logic                     rsp_entry_changed;
   logic                     rsp_table_full;
   logic                     rsp_message_changed;
   logic                     rsp_result_last;

   // Shadow route table
   logic [ADDR_WIDTH-1:0]    shadow_dest [TABLE_DEPTH];
   logic [COST_W-1:0]        shadow_cost [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0]    shadow_next_hop [TABLE_DEPTH];
   logic [ADDR_WIDTH-1:0]    shadow_iface [TABLE_DEPTH];
   int                       shadow_used = 0;
   bit                       shadow_msg_dirty = 1'b0;
   logic [COST_W-1:0]        shadow_max_metric = MAX_METRIC_RESET;

   // Stimulus pools and queues
   logic [FIELD_ADDR_W-1:0]  dest_pool [DEST_POOL_N];
   logic [FIELD_ADDR_W-1:0]  nbr_pool [NBR_POOL_N];
   logic [FIELD_ADDR_W-1:0]  iface_pool [IFACE_POOL_N];
   route_req_type            pending_routes [$];
   route_rsp_type            expected_updates [$];

   int                       snd_idle_pct = 0;
   int                       rcv_idle_pct = 0;
   int                       mismatches = 0;
   int                       routes_checked = 0;
   int                       changes_seen = 0;
   int                       drops_seen = 0;
   int                       messages_seen = 0;
   int                       metric_settings = 0;
   int                       quiet_cycles = 0;

   distance_vector_route_update_top DUT (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_mode            (req_mode),
      .req_dest_addr       (req_dest_addr),
      .req_adv_cost        (req_adv_cost),
      .req_neighbor_addr   (req_neighbor_addr),
      .req_local_if_addr   (req_local_if_addr),
      .req_last_of_message (req_last_of_message),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_entry_index     (rsp_entry_index),
      .rsp_entry_cost      (rsp_entry_cost),
      .rsp_entry_next_hop  (rsp_entry_next_hop),
      .rsp_entry_iface     (rsp_entry_iface),
      .rsp_entry_changed   (rsp_entry_changed),
      .rsp_table_full      (rsp_table_full),
      .rsp_message_changed (rsp_message_changed),
      .rsp_result_last     (rsp_result_last)
   );

   // Clock
   initial begin
      forever #5 clock = ~clock;
   end

   // Route table update as the block should perform it
   function automatic route_rsp_type update_route_table(input route_req_type r);
      route_rsp_type     res;
      logic [COST_W:0]   sum;
      logic [COST_W-1:0] cand;
      int                slot;
      bit                found;
      bit                changed;
      bit                full;
      slot    = 0;
      found   = 1'b0;
      changed = 1'b0;
      full    = 1'b0;
      // candidate cost: direct routes as given, advertised ones plus one, saturated
      if (r.mode == ROUTE_DIRECT) begin
         cand = r.cost;
      end else begin
         sum = {1'b0, r.cost} + 1'b1;
         cand = (sum > {1'b0, shadow_max_metric}) ? shadow_max_metric : sum[COST_W-1:0];
      end
      // lowest matching slot wins
      for (int j = 0; j < shadow_used; j++) begin
         if (!found && shadow_dest[j] == r.dest) begin
            found = 1'b1;
            slot = j;
         end
      end
      if (found) begin
         if (r.mode == ROUTE_DIRECT) begin
            changed = (shadow_cost[slot] != cand) || (shadow_next_hop[slot] != r.neighbor) ||
                      (shadow_iface[slot] != r.iface);
            shadow_cost[slot]     = cand;
            shadow_next_hop[slot] = r.neighbor;
            shadow_iface[slot]    = r.iface;
         end else if (cand < shadow_cost[slot]) begin
            shadow_cost[slot]     = cand;
            shadow_next_hop[slot] = r.neighbor;
            shadow_iface[slot]    = r.iface;
            changed = 1'b1;
         end else if (shadow_next_hop[slot] == r.neighbor && shadow_cost[slot] != cand) begin
            // sender is our next hop: follow its news, good or bad
            shadow_cost[slot] = cand;
            changed = 1'b1;
         end
      end else if (shadow_used < TABLE_DEPTH) begin
         slot = shadow_used;
         shadow_dest[slot]     = r.dest;
         shadow_cost[slot]     = cand;
         shadow_next_hop[slot] = r.neighbor;
         shadow_iface[slot]    = r.iface;
         shadow_used++;
         changed = 1'b1;
      end else begin
         full = 1'b1;
      end
      if (changed) shadow_msg_dirty = 1'b1;
      if (full) begin
         res.index    = '0;
         res.cost     = '0;
         res.next_hop = '0;
         res.iface    = '0;
      end else begin
         res.index    = slot[FIELD_INDEX_W-1:0];
         res.cost     = shadow_cost[slot];
         res.next_hop = shadow_next_hop[slot];
         res.iface    = shadow_iface[slot];
      end
      res.changed     = changed;
      res.full        = full;
      res.msg_changed = r.last && shadow_msg_dirty;
      res.last        = r.last;
      if (r.last) shadow_msg_dirty = 1'b0;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      mismatches++;
   endtask

   task automatic push_route(input logic mode, input logic [FIELD_ADDR_W-1:0] dest,
                             input logic [COST_W-1:0] cost,
                             input logic [FIELD_ADDR_W-1:0] nbr,
                             input logic [FIELD_ADDR_W-1:0] lif, input logic last);
      route_req_type item;
      item = '{mode, dest, cost, nbr, lif, last};
      pending_routes = {pending_routes, item};
   endtask

   function automatic logic [FIELD_ADDR_W-1:0] pick_dest();
      if ($urandom_range(0, 15) == 0) return $urandom;
      return dest_pool[$urandom_range(0, DEST_POOL_N - 1)];
   endfunction

   // costs mostly near the metric range so both cheaper and dearer routes occur
   function automatic logic [COST_W-1:0] pick_cost();
      if ($urandom_range(0, 3) == 0) return COST_W'($urandom_range(0, 255));
      return COST_W'($urandom_range(0, 20));
   endfunction

   // Messages from one neighbour on one interface, plus some direct installs and noise
   task automatic add_random_routes(input int count);
      int                      len;
      int                      kind;
      logic [FIELD_ADDR_W-1:0] nbr;
      logic [FIELD_ADDR_W-1:0] lif;
      while (count > 0) begin
         len  = $urandom_range(1, 6);
         kind = $urandom_range(0, 9);
         nbr  = nbr_pool[$urandom_range(0, NBR_POOL_N - 1)];
         lif  = iface_pool[$urandom_range(0, IFACE_POOL_N - 1)];
         for (int k = 0; k < len && count > 0; k++) begin
            if (kind <= 6) begin
               push_route(ROUTE_ADVERTISED, pick_dest(), pick_cost(), nbr, lif, k == len - 1);
            end else if (kind == 7) begin
               push_route(ROUTE_DIRECT, pick_dest(), pick_cost(), nbr, lif, k == len - 1);
            end else begin
               push_route(1'($urandom_range(0, 1)),
                          $urandom_range(0, 1) ? pick_dest() : $urandom,
                          COST_W'($urandom_range(0, 255)), $urandom, $urandom,
                          1'($urandom_range(0, 1)));
            end
            count--;
         end
      end
   endtask

   // Change max_metric with the block idle
   task automatic write_max_metric(input logic [COST_W-1:0] value);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      shadow_max_metric = value;
      metric_settings++;
   endtask

   // Wait until every request is taken and answered, then let the block settle
   task automatic drain_routes();
      while (pending_routes.size() != 0 || req_valid || expected_updates.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Request driver
   always @(posedge clock) begin : drive_requests
      route_req_type nxt;
      route_rsp_type pred;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            pred = update_route_table('{req_mode, req_dest_addr, req_adv_cost,
               req_neighbor_addr, req_local_if_addr, req_last_of_message});
            expected_updates = {expected_updates, pred};
         end
         if (!req_valid || req_ready) begin
            if (pending_routes.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
               nxt = pending_routes.pop_front();
               req_mode            <= nxt.mode;
               req_dest_addr       <= nxt.dest;
               req_adv_cost        <= nxt.cost;
               req_neighbor_addr   <= nxt.neighbor;
               req_local_if_addr   <= nxt.iface;
               req_last_of_message <= nxt.last;
               req_valid           <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor
   always @(posedge clock) begin : check_responses
      route_rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_updates.size() == 0) begin
               report_mismatch("unexpected response, entry_index", 32'(rsp_entry_index),
                               32'd0);
            end else begin
               want = expected_updates.pop_front();
               routes_checked++;
               if (want.changed) changes_seen++;
               if (want.full) drops_seen++;
               if (want.last) messages_seen++;
               if (rsp_entry_index !== want.index)
                  report_mismatch("entry_index", 32'(rsp_entry_index), 32'(want.index));
               if (rsp_entry_cost !== want.cost)
                  report_mismatch("entry_cost", 32'(rsp_entry_cost), 32'(want.cost));
               if (rsp_entry_next_hop !== want.next_hop)
                  report_mismatch("entry_next_hop", rsp_entry_next_hop, want.next_hop);
               if (rsp_entry_iface !== want.iface)
                  report_mismatch("entry_iface", rsp_entry_iface, want.iface);
               if (rsp_entry_changed !== want.changed)
                  report_mismatch("entry_changed", 32'(rsp_entry_changed),
                                  32'(want.changed));
               if (rsp_table_full !== want.full)
                  report_mismatch("table_full", 32'(rsp_table_full), 32'(want.full));
               if (rsp_message_changed !== want.msg_changed)
                  report_mismatch("message_changed", 32'(rsp_message_changed),
                                  32'(want.msg_changed));
               if (rsp_result_last !== want.last)
                  report_mismatch("result_last", 32'(rsp_result_last), 32'(want.last));
            end
         end
         rsp_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
   end

   // Watchdog: no request or response moving for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Timeout: no request or response for %0d cycles", STALL_LIMIT);
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Sequence of phases
   initial begin
      dest_pool[0] = '0;
      dest_pool[1] = '1;
      for (int i = 2; i < DEST_POOL_N; i++) dest_pool[i] = $urandom;
      nbr_pool[0] = '0;
      nbr_pool[1] = '1;
      for (int i = 2; i < NBR_POOL_N; i++) nbr_pool[i] = $urandom;
      iface_pool[0] = '0;
      iface_pool[1] = '1;
      iface_pool[2] = $urandom;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset metric of 16, empty table
      snd_idle_pct = 24;
      rcv_idle_pct = 85;
      push_route(ROUTE_ADVERTISED, dest_pool[0], 8'd0, nbr_pool[2], iface_pool[2], 1'b0);
      push_route(ROUTE_ADVERTISED, dest_pool[1], 8'd255, nbr_pool[1], iface_pool[1], 1'b1);
      // equal cost via another neighbour: ignored
      push_route(ROUTE_ADVERTISED, dest_pool[0], 8'd0, nbr_pool[3], iface_pool[0], 1'b1);
      // next hop reports a worse cost: only the cost follows
      push_route(ROUTE_ADVERTISED, dest_pool[0], 8'd5, nbr_pool[2], iface_pool[0], 1'b0);
      push_route(ROUTE_ADVERTISED, dest_pool[0], 8'd5, nbr_pool[2], iface_pool[2], 1'b1);
      // cheaper route replaces, then poisoned by its own next hop
      push_route(ROUTE_ADVERTISED, dest_pool[1], 8'd3, nbr_pool[3], iface_pool[2], 1'b0);
      push_route(ROUTE_ADVERTISED, dest_pool[1], 8'd15, nbr_pool[3], iface_pool[2], 1'b1);
      // direct install over an existing route, then repeated unchanged
      push_route(ROUTE_DIRECT, dest_pool[0], 8'd200, nbr_pool[0], iface_pool[1], 1'b0);
      push_route(ROUTE_DIRECT, dest_pool[0], 8'd200, nbr_pool[0], iface_pool[1], 1'b1);
      // direct install of a new destination keeps its cost unsaturated
      push_route(ROUTE_DIRECT, dest_pool[2], 8'd255, nbr_pool[1], iface_pool[0], 1'b1);
      push_route(ROUTE_ADVERTISED, dest_pool[2], 8'd254, nbr_pool[0], iface_pool[2], 1'b0);
      push_route(ROUTE_ADVERTISED, dest_pool[2], 8'd255, nbr_pool[0], iface_pool[2], 1'b1);
      push_route(ROUTE_DIRECT, dest_pool[1], 8'd0, nbr_pool[0], iface_pool[0], 1'b1);
      push_route(ROUTE_ADVERTISED, dest_pool[1], 8'd0, nbr_pool[0], iface_pool[0], 1'b1);
      drain_routes();

      write_max_metric(8'd255);
      add_random_routes(500);
      drain_routes();

      snd_idle_pct = 85;
      rcv_idle_pct = 24;
      write_max_metric(8'd1);
      add_random_routes(300);
      drain_routes();

      // zero metric: every advertised candidate becomes zero
      write_max_metric(8'd0);
      add_random_routes(300);
      drain_routes();

      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      write_max_metric(COST_W'($urandom_range(2, 254)));
      add_random_routes(400);
      drain_routes();

      write_max_metric(MAX_METRIC_RESET);
      add_random_routes(500);
      drain_routes();

      if (expected_updates.size() != 0)
         report_mismatch("responses missing, count", 32'(expected_updates.size()), 32'd0);
      $display("Checked %0d route updates under %0d max_metric settings plus reset value.",
               routes_checked, metric_settings);
      $display("%0d entries changed, %0d routes dropped on a full table, %0d messages closed.",
               changes_seen, drops_seen, messages_seen);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: distance_vector_route_update_top.f
rtl/dvr_pkg.sv
rtl/dvr_ram.sv
rtl/dvr_datapath.sv
rtl/dvr_ctrl.sv
rtl/distance_vector_route_update_top.sv
test/tb_distance_vector_route_update_top.sv
